FILE: sv/lob_pkg.sv
// Shared types, codes and defaults of the limit order book matcher.
package lob_pkg;

    localparam int ORDER_SLOTS_DEF = 32;
    localparam int PRICE_BITS_DEF  = 16;

    localparam logic [1:0] REQ_LIMIT  = 2'd0;
    localparam logic [1:0] REQ_MARKET = 2'd1;
    localparam logic [1:0] REQ_CANCEL = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] KIND_FILL   = 2'd0;
    localparam logic [1:0] KIND_ACK    = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic [1:0] REJ_NO_LIQ    = 2'd0;
    localparam logic [1:0] REJ_NOT_FOUND = 2'd1;
    localparam logic [1:0] REJ_FULL      = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_MATCH_SCAN,
        ST_FILL,
        ST_TAKER_END,
        ST_FREE_SCAN,
        ST_REST,
        ST_CANCEL_SCAN
    } lob_state_t;

    typedef enum logic [1:0] {
        SCAN_MATCH,
        SCAN_CANCEL,
        SCAN_FREE
    } scan_mode_t;

    typedef struct packed {
        logic       load;
        logic       idle;
        logic       scan_start;
        scan_mode_t scan_mode;
        logic       fill;
        logic       rest;
        logic       cancel;
        logic       emit;
        logic [1:0] kind;
        logic [1:0] code;
        logic       last;
    } lob_cmd_t;

    typedef struct packed {
        logic req_valid;
        logic scan_busy;
        logic found;
        logic is_cancel;
        logic is_market;
        logic is_unused;
        logic rem_zero;
        logic rem_done_after_fill;
        logic had_fill;
        logic out_free;
    } lob_status_t;

endpackage

FILE: sv/lob_req_if.sv
// Request channel of the order book: valid, ready and the request fields.
interface lob_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] order_id;
    logic        is_sell;
    logic [15:0] limit_price;
    logic [15:0] quantity;

    modport source (output valid, req_type, order_id, is_sell, limit_price, quantity,
                    input ready);
    modport sink (input valid, req_type, order_id, is_sell, limit_price, quantity,
                  output ready);
endinterface

FILE: sv/lob_res_if.sv
// Result channel of the order book: valid, ready and the result fields.
interface lob_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [31:0] result_id;
    logic [15:0] fill_qty;
    logic [15:0] fill_price;
    logic [1:0]  reject_code;
    logic        last_result;

    modport source (output valid, result_kind, result_id, fill_qty, fill_price,
                    reject_code, last_result, input ready);
    modport sink (input valid, result_kind, result_id, fill_qty, fill_price,
                  reject_code, last_result, output ready);
endinterface

FILE: sv/lob_ctrl.sv
// Controller state machine that sequences scans, fills, resting and results.
module lob_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  lob_pkg::lob_status_t sts,
    output lob_pkg::lob_cmd_t    cmd
);
    import lob_pkg::*;

    lob_state_t state_reg;
    lob_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sts.req_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (sts.is_unused)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.is_cancel)
                begin
                    state_next = ST_CANCEL_SCAN;
                end
                else if (sts.rem_zero)
                begin
                    state_next = ST_TAKER_END;
                end
                else
                begin
                    state_next = ST_MATCH_SCAN;
                end
            end
            ST_MATCH_SCAN:
            begin
                if (!sts.scan_busy)
                begin
                    state_next = sts.found ? ST_FILL : ST_TAKER_END;
                end
            end
            ST_FILL:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.rem_done_after_fill ? ST_TAKER_END : ST_MATCH_SCAN;
                end
            end
            ST_TAKER_END:
            begin
                if (!sts.is_market && !sts.rem_zero)
                begin
                    state_next = ST_FREE_SCAN;
                end
                else if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FREE_SCAN:
            begin
                if (!sts.scan_busy)
                begin
                    if (sts.found)
                    begin
                        state_next = ST_REST;
                    end
                    else if (sts.out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_REST:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CANCEL_SCAN:
            begin
                if (!sts.scan_busy && sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.scan_mode = SCAN_MATCH;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.idle = 1'b1;
                cmd.load = sts.req_valid;
            end
            ST_DISPATCH:
            begin
                if (!sts.is_unused)
                begin
                    if (sts.is_cancel)
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_mode  = SCAN_CANCEL;
                    end
                    else if (!sts.rem_zero)
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_mode  = SCAN_MATCH;
                    end
                end
            end
            ST_MATCH_SCAN:
            begin
                cmd.scan_mode = SCAN_MATCH;
            end
            ST_FILL:
            begin
                if (sts.out_free)
                begin
                    cmd.fill = 1'b1;
                    cmd.emit = 1'b1;
                    cmd.kind = KIND_FILL;
                    if (!sts.rem_done_after_fill)
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_mode  = SCAN_MATCH;
                    end
                end
            end
            ST_TAKER_END:
            begin
                if (!sts.is_market && !sts.rem_zero)
                begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_mode  = SCAN_FREE;
                end
                else if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = 1'b1;
                    if (sts.is_market && !sts.had_fill)
                    begin
                        cmd.kind = KIND_REJECT;
                        cmd.code = REJ_NO_LIQ;
                    end
                    else
                    begin
                        cmd.kind = KIND_ACK;
                    end
                end
            end
            ST_FREE_SCAN:
            begin
                if (!sts.scan_busy && !sts.found && sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = 1'b1;
                    cmd.kind = KIND_REJECT;
                    cmd.code = REJ_FULL;
                end
            end
            ST_REST:
            begin
                if (sts.out_free)
                begin
                    cmd.rest = 1'b1;
                    cmd.emit = 1'b1;
                    cmd.last = 1'b1;
                    cmd.kind = KIND_ACK;
                end
            end
            ST_CANCEL_SCAN:
            begin
                if (!sts.scan_busy && sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = 1'b1;
                    if (sts.found)
                    begin
                        cmd.cancel = 1'b1;
                        cmd.kind   = KIND_ACK;
                    end
                    else
                    begin
                        cmd.kind = KIND_REJECT;
                        cmd.code = REJ_NOT_FOUND;
                    end
                end
            end
            default:
            begin
                cmd.idle = 1'b0;
            end
        endcase
    end

endmodule

FILE: sv/lob_datapath.sv
// Datapath: order slot memories, slot scan with best-maker tracking, output register.
module lob_datapath #(
    parameter int ORDER_SLOTS = lob_pkg::ORDER_SLOTS_DEF,
    parameter int PRICE_BITS  = lob_pkg::PRICE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    lob_req_if.sink              req,
    lob_res_if.source            res,
    input  lob_pkg::lob_cmd_t    cmd,
    output lob_pkg::lob_status_t sts
);
    import lob_pkg::*;

    localparam int IDX_W = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ORDER_SLOTS - 1);

    // Slot storage; only the valid bits are reset.
    logic                  mem_sell  [ORDER_SLOTS];
    logic [PRICE_BITS-1:0] mem_price [ORDER_SLOTS];
    logic [15:0]           mem_qty   [ORDER_SLOTS];
    logic [31:0]           mem_id    [ORDER_SLOTS];
    logic [31:0]           mem_arr   [ORDER_SLOTS];
    logic [ORDER_SLOTS-1:0] valid_reg;
    logic [ORDER_SLOTS-1:0] valid_next;

    logic                  rd_sell_reg;
    logic [PRICE_BITS-1:0] rd_price_reg;
    logic [15:0]           rd_qty_reg;
    logic [31:0]           rd_id_reg;
    logic [31:0]           rd_arr_reg;

    // Taker request.
    logic [1:0]            type_reg;
    logic [31:0]           id_reg;
    logic                  sell_reg;
    logic [PRICE_BITS-1:0] limit_reg;
    logic [15:0]           rem_reg;
    logic                  had_fill_reg;
    logic [31:0]           counter_reg;

    // Scan pipeline and best candidate.
    scan_mode_t            mode_reg;
    logic                  busy_reg;
    logic                  issue_reg;
    logic [IDX_W-1:0]      issue_addr_reg;
    logic                  chk_reg;
    logic [IDX_W-1:0]      chk_idx_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [PRICE_BITS-1:0] best_price_reg;
    logic [15:0]           best_qty_reg;
    logic [31:0]           best_age_reg;

    // Output register.
    logic                  out_valid_reg;
    logic [1:0]            out_kind_reg;
    logic [31:0]           out_id_reg;
    logic [15:0]           out_qty_reg;
    logic [15:0]           out_price_reg;
    logic [1:0]            out_code_reg;
    logic                  out_last_reg;

    logic                  chk_valid;
    logic [31:0]           chk_age;
    logic                  price_ok;
    logic                  better;
    logic                  take;
    logic [15:0]           fill_q;
    logic                  out_free;

    assign chk_valid = valid_reg[chk_idx_reg];
    assign chk_age   = counter_reg - rd_arr_reg;
    assign out_free  = !out_valid_reg || res.ready;
    assign fill_q    = (rem_reg < best_qty_reg) ? rem_reg : best_qty_reg;

    always_comb
    begin
        price_ok = 1'b1;
        if (type_reg == REQ_LIMIT)
        begin
            price_ok = sell_reg ? (rd_price_reg >= limit_reg) : (rd_price_reg <= limit_reg);
        end
        better = !found_reg
            || (sell_reg ? (rd_price_reg > best_price_reg) : (rd_price_reg < best_price_reg))
            || ((rd_price_reg == best_price_reg) && (chk_age > best_age_reg));
        take = 1'b0;
        case (mode_reg)
            SCAN_MATCH:  take = chk_valid && (rd_sell_reg != sell_reg) && price_ok && better;
            SCAN_CANCEL: take = chk_valid && (rd_id_reg == id_reg) && !found_reg;
            SCAN_FREE:   take = !chk_valid && !found_reg;
            default:     take = 1'b0;
        endcase
        take = take && chk_reg;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.fill && (best_qty_reg <= rem_reg))
        begin
            valid_next[best_idx_reg] = 1'b0;
        end
        if (cmd.cancel)
        begin
            valid_next[best_idx_reg] = 1'b0;
        end
        if (cmd.rest)
        begin
            valid_next[best_idx_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_reg)
        begin
            rd_sell_reg  <= mem_sell[issue_addr_reg];
            rd_price_reg <= mem_price[issue_addr_reg];
            rd_qty_reg   <= mem_qty[issue_addr_reg];
            rd_id_reg    <= mem_id[issue_addr_reg];
            rd_arr_reg   <= mem_arr[issue_addr_reg];
        end
        if (cmd.fill)
        begin
            mem_qty[best_idx_reg] <= best_qty_reg - fill_q;
        end
        if (cmd.rest)
        begin
            mem_sell[best_idx_reg]  <= sell_reg;
            mem_price[best_idx_reg] <= limit_reg;
            mem_qty[best_idx_reg]   <= rem_reg;
            mem_id[best_idx_reg]    <= id_reg;
            mem_arr[best_idx_reg]   <= counter_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            type_reg  <= req.req_type;
            id_reg    <= req.order_id;
            sell_reg  <= req.is_sell;
            limit_reg <= PRICE_BITS'(req.limit_price);
            rem_reg   <= req.quantity;
        end
        else if (cmd.fill)
        begin
            rem_reg <= rem_reg - fill_q;
        end
        if (cmd.scan_start)
        begin
            mode_reg <= cmd.scan_mode;
        end
        if (take)
        begin
            best_idx_reg   <= chk_idx_reg;
            best_price_reg <= rd_price_reg;
            best_qty_reg   <= rd_qty_reg;
            best_age_reg   <= chk_age;
        end
        if (issue_reg)
        begin
            chk_idx_reg <= issue_addr_reg;
        end
        if (cmd.emit)
        begin
            out_kind_reg  <= cmd.kind;
            out_id_reg    <= id_reg;
            out_qty_reg   <= (cmd.kind == KIND_FILL) ? fill_q : 16'd0;
            out_price_reg <= (cmd.kind == KIND_FILL) ? 16'(best_price_reg) : 16'd0;
            out_code_reg  <= cmd.code;
            out_last_reg  <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            counter_reg    <= '0;
            had_fill_reg   <= 1'b0;
            busy_reg       <= 1'b0;
            issue_reg      <= 1'b0;
            issue_addr_reg <= '0;
            chk_reg        <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cmd.rest)
            begin
                counter_reg <= counter_reg + 32'd1;
            end
            if (cmd.load)
            begin
                had_fill_reg <= 1'b0;
            end
            else if (cmd.fill)
            begin
                had_fill_reg <= 1'b1;
            end

            if (cmd.scan_start)
            begin
                busy_reg       <= 1'b1;
                issue_reg      <= 1'b1;
                issue_addr_reg <= '0;
                chk_reg        <= 1'b0;
                found_reg      <= 1'b0;
            end
            else
            begin
                chk_reg <= issue_reg;
                if (issue_reg)
                begin
                    if (issue_addr_reg == LAST_IDX)
                    begin
                        issue_reg <= 1'b0;
                    end
                    else
                    begin
                        issue_addr_reg <= issue_addr_reg + 1'b1;
                    end
                end
                if (take)
                begin
                    found_reg <= 1'b1;
                end
                if (chk_reg && (chk_idx_reg == LAST_IDX))
                begin
                    busy_reg <= 1'b0;
                end
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign req.ready = cmd.idle;

    assign res.valid       = out_valid_reg;
    assign res.result_kind = out_kind_reg;
    assign res.result_id   = out_id_reg;
    assign res.fill_qty    = out_qty_reg;
    assign res.fill_price  = out_price_reg;
    assign res.reject_code = out_code_reg;
    assign res.last_result = out_last_reg;

    always_comb
    begin
        sts.req_valid           = req.valid;
        sts.scan_busy           = busy_reg;
        sts.found               = found_reg;
        sts.is_cancel           = (type_reg == REQ_CANCEL);
        sts.is_market           = (type_reg == REQ_MARKET);
        sts.is_unused           = (type_reg == REQ_UNUSED);
        sts.rem_zero            = (rem_reg == 16'd0);
        sts.rem_done_after_fill = (rem_reg <= best_qty_reg);
        sts.had_fill            = had_fill_reg;
        sts.out_free            = out_free;
    end

endmodule

FILE: sv/limit_order_book_matcher.sv
// Price-time priority order book: every scan walks the ORDER_SLOTS slot memory one slot per
// cycle. A taker passes a dispatch state, one scan and fill per trade, a further scan when it
// still has quantity after its last fill, and a closing result; a resting remainder adds a
// free-slot scan and the write. A cancel takes one scan. The controller returns to idle and
// accepts the next request once the closing result is taken into the output register. One
// request is handled at a time; results leave through a register that holds while the sink
// stalls, and a stalled sink holds up the request.
module limit_order_book_matcher #(
    parameter int ORDER_SLOTS = lob_pkg::ORDER_SLOTS_DEF,
    parameter int PRICE_BITS  = lob_pkg::PRICE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    lob_req_if.sink    req,
    lob_res_if.source  res
);
    import lob_pkg::*;

    lob_cmd_t    cmd;
    lob_status_t sts;

    lob_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    lob_datapath #(
        .ORDER_SLOTS (ORDER_SLOTS),
        .PRICE_BITS  (PRICE_BITS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res),
        .cmd   (cmd),
        .sts   (sts)
    );

    // A fill always trades a non-zero amount and is never the final result.
    a_fill_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.result_kind == KIND_FILL) |-> (res.fill_qty != 16'd0) && !res.last_result)
        else $error("fill result malformed");

    // Results other than rejects carry a reject code of zero.
    a_code_only_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.result_kind != KIND_REJECT) |-> (res.reject_code == REJ_NO_LIQ))
        else $error("reject code on non-reject result");

    // Once a request is taken, no further request is taken until it is finished.
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while busy");

endmodule

FILE: verif/limit_order_book_matcher_test.sv
// Self-checking testbench of the limit order book matcher: directed and random requests against a predictor.
`timescale 1ns / 100ps

module limit_order_book_matcher_test;
    import lob_pkg::*;

    localparam int SLOTS = ORDER_SLOTS_DEF;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] order_id;
        logic        is_sell;
        logic [15:0] limit_price;
        logic [15:0] quantity;
    } book_req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] id;
        logic [15:0] qty;
        logic [15:0] price;
        logic [1:0]  code;
        logic        last;
    } book_res_t;

    logic clk = 1'b0;
    logic rst_n;

    lob_req_if req();
    lob_res_if res();

    limit_order_book_matcher DUT (.clk(clk), .rst_n(rst_n), .req(req), .res(res));

    always #5 clk = ~clk;

    // Predicted book contents.
    logic        bk_valid [SLOTS];
    logic        bk_sell [SLOTS];
    logic [15:0] bk_price [SLOTS];
    logic [15:0] bk_qty [SLOTS];
    logic [31:0] bk_id [SLOTS];
    logic [31:0] bk_arrival [SLOTS];
    logic [31:0] arrival_seq;

    book_req_t pending_reqs[$];
    book_res_t expected_results[$];
    int unsigned mismatches;
    int unsigned fills_seen;
    int unsigned results_seen;
    int unsigned reqs_sent;
    logic calm;
    logic [31:0] next_id;

    function automatic int find_best_maker(logic taker_sell, logic market, logic [15:0] lim);
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!bk_valid[i] || bk_sell[i] == taker_sell)
                continue;
            if (!market && !taker_sell && bk_price[i] > lim)
                continue;
            if (!market && taker_sell && bk_price[i] < lim)
                continue;
            if (best < 0)
            begin
                best = i;
                continue;
            end
            if (taker_sell ? (bk_price[i] > bk_price[best]) : (bk_price[i] < bk_price[best]))
            begin
                best = i;
                continue;
            end
            if (bk_price[i] != bk_price[best])
                continue;
            if (32'(arrival_seq - bk_arrival[i]) > 32'(arrival_seq - bk_arrival[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic void push_result(logic [1:0] kind, logic [31:0] id, logic [15:0] q,
                                        logic [15:0] p, logic [1:0] code, logic last);
        book_res_t r;
        r = '{kind, id, q, p, code, last};
        expected_results = {expected_results, r};
    endfunction

    function automatic void predict_book(book_req_t r);
        logic [15:0] remaining;
        logic [15:0] traded;
        int best;
        int free_slot;
        int nfills;
        logic market;
        remaining = r.quantity;
        nfills = 0;
        free_slot = -1;
        market = (r.req_type == REQ_MARKET);
        if (r.req_type == REQ_UNUSED)
            return;
        if (r.req_type == REQ_CANCEL)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (bk_valid[i] && bk_id[i] == r.order_id)
                begin
                    bk_valid[i] = 1'b0;
                    push_result(KIND_ACK, r.order_id, 16'd0, 16'd0, REJ_NO_LIQ, 1'b1);
                    return;
                end
            end
            push_result(KIND_REJECT, r.order_id, 16'd0, 16'd0, REJ_NOT_FOUND, 1'b1);
            return;
        end
        while (remaining != 16'd0)
        begin
            best = find_best_maker(r.is_sell, market, r.limit_price);
            if (best < 0)
                break;
            traded = (remaining < bk_qty[best]) ? remaining : bk_qty[best];
            push_result(KIND_FILL, r.order_id, traded, bk_price[best], REJ_NO_LIQ, 1'b0);
            nfills++;
            remaining -= traded;
            bk_qty[best] -= traded;
            if (bk_qty[best] == 16'd0)
                bk_valid[best] = 1'b0;
        end
        if (market)
        begin
            if (nfills > 0)
                push_result(KIND_ACK, r.order_id, 16'd0, 16'd0, REJ_NO_LIQ, 1'b1);
            else
                push_result(KIND_REJECT, r.order_id, 16'd0, 16'd0, REJ_NO_LIQ, 1'b1);
            return;
        end
        if (remaining != 16'd0)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!bk_valid[i])
                begin
                    free_slot = i;
                    break;
                end
            end
            if (free_slot < 0)
            begin
                push_result(KIND_REJECT, r.order_id, 16'd0, 16'd0, REJ_FULL, 1'b1);
                return;
            end
            bk_valid[free_slot] = 1'b1;
            bk_sell[free_slot] = r.is_sell;
            bk_price[free_slot] = r.limit_price;
            bk_qty[free_slot] = remaining;
            bk_id[free_slot] = r.order_id;
            bk_arrival[free_slot] = arrival_seq;
            arrival_seq++;
        end
        push_result(KIND_ACK, r.order_id, 16'd0, 16'd0, REJ_NO_LIQ, 1'b1);
    endfunction

    function automatic void queue_req(logic [1:0] t, logic [31:0] id, logic s,
                                      logic [15:0] p, logic [15:0] q);
        book_req_t r;
        r = '{t, id, s, p, q};
        pending_reqs = {pending_reqs, r};
    endfunction

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.req_type <= REQ_LIMIT;
            req.order_id <= '0;
            req.is_sell <= 1'b0;
            req.limit_price <= '0;
            req.quantity <= '0;
        end
        else if (!req.valid || req.ready)
        begin
            if (req.valid && req.ready)
            begin
                predict_book(pending_reqs[0]);
                pending_reqs.delete(0);
                reqs_sent++;
            end
            if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 25))
            begin
                req.valid <= 1'b1;
                {req.req_type, req.order_id, req.is_sell, req.limit_price, req.quantity}
                    <= pending_reqs[0];
            end
            else
            begin
                req.valid <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge clk or negedge rst_n)
    begin
        book_res_t got;
        book_res_t want;
        if (!rst_n)
        begin
            res.ready <= 1'b0;
        end
        else
        begin
            res.ready <= calm || ($urandom_range(99) >= 25);
            if (res.valid && res.ready)
            begin
                got = '{res.result_kind, res.result_id, res.fill_qty, res.fill_price,
                        res.reject_code, res.last_result};
                results_seen++;
                if (got.kind == KIND_FILL)
                    fills_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result %p", got);
                end
                else
                begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Result mismatch: expected %p, got %p", want, got);
                    end
                end
            end
        end
    end

    // Random requests: mostly limit orders near a mid price so that they cross.
    task automatic add_random_reqs(int count);
        int pick;
        logic [31:0] id;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 15 && next_id > 1000)
                id = 1000 + $urandom_range(next_id - 1000);
            else
            begin
                id = next_id;
                next_id++;
            end
            if (pick < 15)
                queue_req(REQ_CANCEL, ($urandom_range(9) == 0) ? $urandom : id,
                          1'($urandom_range(1)), 16'($urandom), 16'($urandom));
            else if (pick < 25)
                queue_req(REQ_MARKET, id, 1'($urandom_range(1)), 16'($urandom),
                          16'($urandom_range(1, 300)));
            else if (pick < 27)
                queue_req(REQ_UNUSED, $urandom, 1'($urandom_range(1)), 16'($urandom),
                          16'($urandom));
            else if (pick < 31)
                queue_req(REQ_LIMIT, $urandom, 1'($urandom_range(1)), 16'($urandom),
                          16'($urandom));
            else
                queue_req(REQ_LIMIT, id, 1'($urandom_range(1)),
                          16'(1000 + $urandom_range(20)), 16'($urandom_range(1, 200)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            bk_valid[i] = 1'b0;
            bk_sell[i] = 1'b0;
            bk_price[i] = '0;
            bk_qty[i] = '0;
            bk_id[i] = '0;
            bk_arrival[i] = '0;
        end
        arrival_seq = '0;
        mismatches = 0;
        fills_seen = 0;
        results_seen = 0;
        reqs_sent = 0;
        calm = 1'b0;
        next_id = 1000;

        // Directed part: empty book cases, extremes, price-time priority, full book.
        queue_req(REQ_MARKET, 32'd1, 1'b0, 16'd0, 16'd10);
        queue_req(REQ_CANCEL, 32'hFFFF_FFFF, 1'b0, 16'd0, 16'd0);
        queue_req(REQ_LIMIT, 32'd2, 1'b0, 16'd5, 16'd0);
        queue_req(REQ_MARKET, 32'd3, 1'b1, 16'd0, 16'd0);
        queue_req(REQ_UNUSED, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF);
        queue_req(REQ_LIMIT, 32'd10, 1'b1, 16'hFFFF, 16'hFFFF);
        queue_req(REQ_LIMIT, 32'd11, 1'b1, 16'd100, 16'd5);
        queue_req(REQ_LIMIT, 32'd12, 1'b1, 16'd100, 16'd7);
        queue_req(REQ_LIMIT, 32'd13, 1'b1, 16'd90, 16'd3);
        queue_req(REQ_LIMIT, 32'd12, 1'b1, 16'd95, 16'd2);
        queue_req(REQ_LIMIT, 32'd14, 1'b0, 16'd99, 16'd10);
        queue_req(REQ_LIMIT, 32'd15, 1'b0, 16'd0, 16'd4);
        queue_req(REQ_CANCEL, 32'd12, 1'b0, 16'd0, 16'd0);
        queue_req(REQ_MARKET, 32'd16, 1'b0, 16'd0, 16'd20);
        queue_req(REQ_MARKET, 32'd17, 1'b1, 16'd0, 16'hFFFF);
        queue_req(REQ_CANCEL, 32'd10, 1'b0, 16'd0, 16'd0);
        queue_req(REQ_CANCEL, 32'd10, 1'b0, 16'd0, 16'd0);
        // Fill the book; a remainder after a fill then takes the freed slot and the next order finds no room.
        for (int i = 0; i < SLOTS; i++)
            queue_req(REQ_LIMIT, 32'(100 + i), 1'b0, 16'd50 + i[15:0], 16'd1);
        queue_req(REQ_LIMIT, 32'd200, 1'b1, 16'd81, 16'd5);
        queue_req(REQ_LIMIT, 32'd201, 1'b0, 16'd60, 16'd1);
        queue_req(REQ_MARKET, 32'd202, 1'b1, 16'd0, 16'd40);

        add_random_reqs(190);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_reqs.size() != 0)
            @(posedge clk);
        @(posedge clk);
        // A stretch with no idling on either side.
        calm <= 1'b1;
        add_random_reqs(40);
        while (pending_reqs.size() != 0)
            @(posedge clk);
        @(posedge clk);
        calm <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Sent %0d requests and checked %0d results, %0d of them fills.",
                 reqs_sent, results_seen, fills_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
